// File: src/rhv_pkg.sv
// Shared types and constants for the integer RGB to HSV core.
// No dependencies.
package rhv_pkg;

	localparam int CHANNEL_BITS = 16;
	localparam int FIELD_BITS   = 16;
	localparam int HUE_BITS     = 9;
	localparam int SAT_BITS     = 7;
	localparam int QUO_BITS     = HUE_BITS;
	localparam int SECTOR_DEG   = 60;
	localparam int PCT_FULL     = 100;

	typedef enum logic [1:0] {
		SEC_RED_UP   = 2'd0,
		SEC_GREEN    = 2'd1,
		SEC_BLUE     = 2'd2,
		SEC_RED_WRAP = 2'd3
	} sector_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] red;
		logic [FIELD_BITS-1:0] green;
		logic [FIELD_BITS-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [HUE_BITS-1:0]   hue;
		logic [SAT_BITS-1:0]   saturation;
		logic [FIELD_BITS-1:0] brightness;
	} hsv_t;

endpackage

// File: src/rhv_stream_if.sv
// Valid/ready stream channel carrying one request payload.
// Payload type is supplied by the instantiating scope.
interface rhv_stream_if #(parameter type payload_t = logic);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

// File: src/rgb_to_hsv_integer_core.sv
// Integer RGB to HSV core: hue in degrees, saturation in percent, value = max channel.
// A request passes the three front stages and then the nine-stage restoring divider,
// which yields one quotient bit per stage. Throughput: one request per cycle while the
// result side is ready or the pipeline holds an empty stage.
// Reset clears every stage valid bit; payload registers are not reset.
// Depends on rhv_pkg, rhv_stream_if, rhv_front and rhv_divider.
module rgb_to_hsv_integer_core #(
	parameter int CHANNEL_BITS = rhv_pkg::CHANNEL_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	rhv_stream_if.sink    pix,
	rhv_stream_if.source  hsv
);

	localparam int CB = CHANNEL_BITS;
	localparam int RW = CB + rhv_pkg::QUO_BITS;

	logic                         f_valid, f_ready;
	logic [RW-1:0]                f_rem_h, f_rem_s;
	logic [CB-1:0]                f_div_h, f_div_s, f_top;
	logic [rhv_pkg::QUO_BITS-1:0] q_h, q_s;
	logic [CB-1:0]                d_top;
	rhv_pkg::pixel_t              pix_req;
	rhv_pkg::hsv_t                hsv_res;

	assign pix_req = pix.payload;

	rhv_front #(
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_ready  (pix.ready),
		.red       (pix_req.red),
		.green     (pix_req.green),
		.blue      (pix_req.blue),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.rem_h     (f_rem_h),
		.rem_s     (f_rem_s),
		.div_h     (f_div_h),
		.div_s     (f_div_s),
		.top       (f_top)
	);

	rhv_divider #(
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.rem_h     (f_rem_h),
		.rem_s     (f_rem_s),
		.div_h     (f_div_h),
		.div_s     (f_div_s),
		.top       (f_top),
		.out_valid (hsv.valid),
		.out_ready (hsv.ready),
		.q_h       (q_h),
		.q_s       (q_s),
		.out_top   (d_top)
	);

	always_comb begin
		hsv_res.hue        = q_h;
		hsv_res.saturation = q_s[rhv_pkg::SAT_BITS-1:0];
		hsv_res.brightness = rhv_pkg::FIELD_BITS'(d_top);
	end

	assign hsv.payload = hsv_res;

endmodule

// File: src/rhv_front.sv
// Front stages: channel max/min and sector select, hue numerator, scaled dividends.
// Depends on rhv_pkg.
module rhv_front #(
	parameter int CHANNEL_BITS = rhv_pkg::CHANNEL_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [rhv_pkg::FIELD_BITS-1:0]       red,
	input  logic [rhv_pkg::FIELD_BITS-1:0]       green,
	input  logic [rhv_pkg::FIELD_BITS-1:0]       blue,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [CHANNEL_BITS+rhv_pkg::QUO_BITS-1:0] rem_h,
	output logic [CHANNEL_BITS+rhv_pkg::QUO_BITS-1:0] rem_s,
	output logic [CHANNEL_BITS-1:0]              div_h,
	output logic [CHANNEL_BITS-1:0]              div_s,
	output logic [CHANNEL_BITS-1:0]              top
);

	localparam int CB = CHANNEL_BITS;
	localparam int NW = CB + 3;
	localparam int RW = CB + rhv_pkg::QUO_BITS;

	logic [CB-1:0] r, g, b;
	logic          r_max, g_ge_b, b_ge_r, r_ge_g;
	logic [CB-1:0] top_c, bot_c, d_c;
	logic          neg_c;
	rhv_pkg::sector_t sec_c;

	logic                en1, en2, en3;
	logic                v_s1, v_s2, v_s3;
	logic [CB-1:0]       top_s1, bot_s1, d_s1;
	logic                neg_s1;
	rhv_pkg::sector_t    sec_s1;

	logic [CB-1:0]       span_c;
	logic [NW-1:0]       kspan_c, num_c;
	logic [CB-1:0]       span_s2, top_s2;
	logic [NW-1:0]       num_s2;

	logic [RW-1:0]       rem_h_s3, rem_s_s3;
	logic [CB-1:0]       div_h_s3, div_s_s3, top_s3;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign r = red[CB-1:0];
	assign g = green[CB-1:0];
	assign b = blue[CB-1:0];

	always_comb begin
		r_max  = (r >= g) && (r >= b);
		g_ge_b = g >= b;
		b_ge_r = b >= r;
		r_ge_g = r >= g;
		top_c  = r_max ? r : (g_ge_b ? g : b);
		if ((r <= g) && (r <= b))
			bot_c = r;
		else
			bot_c = (g <= b) ? g : b;
		if (r_max) begin
			if (g_ge_b) begin
				sec_c = rhv_pkg::SEC_RED_UP;
				d_c   = g - b;
				neg_c = 1'b0;
			end else begin
				sec_c = rhv_pkg::SEC_RED_WRAP;
				d_c   = b - g;
				neg_c = 1'b1;
			end
		end else if (g_ge_b) begin
			sec_c = rhv_pkg::SEC_GREEN;
			d_c   = b_ge_r ? b - r : r - b;
			neg_c = !b_ge_r;
		end else begin
			sec_c = rhv_pkg::SEC_BLUE;
			d_c   = r_ge_g ? r - g : g - r;
			neg_c = !r_ge_g;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en1)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			top_s1 <= top_c;
			bot_s1 <= bot_c;
			d_s1   <= d_c;
			neg_s1 <= neg_c;
			sec_s1 <= sec_c;
		end
	end

	assign span_c = top_s1 - bot_s1;

	always_comb begin
		case (sec_s1)
			rhv_pkg::SEC_RED_UP:   kspan_c = '0;
			rhv_pkg::SEC_GREEN:    kspan_c = NW'(span_c) << 1;
			rhv_pkg::SEC_BLUE:     kspan_c = NW'(span_c) << 2;
			rhv_pkg::SEC_RED_WRAP: kspan_c = (NW'(span_c) << 2) + (NW'(span_c) << 1);
			default:               kspan_c = '0;
		endcase
		num_c = neg_s1 ? kspan_c - NW'(d_s1) : kspan_c + NW'(d_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			span_s2 <= span_c;
			top_s2  <= top_s1;
			num_s2  <= num_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			rem_h_s3 <= RW'(num_s2) * RW'(rhv_pkg::SECTOR_DEG);
			rem_s_s3 <= RW'(span_s2) * RW'(rhv_pkg::PCT_FULL);
			div_h_s3 <= (span_s2 == '0) ? CB'(1) : span_s2;
			div_s_s3 <= (top_s2 == '0) ? CB'(1) : top_s2;
			top_s3   <= top_s2;
		end
	end

	assign out_valid = v_s3;
	assign rem_h     = rem_h_s3;
	assign rem_s     = rem_s_s3;
	assign div_h     = div_h_s3;
	assign div_s     = div_s_s3;
	assign top       = top_s3;

endmodule

// File: src/rhv_div_step.sv
// One registered restoring-division step for hue and saturation in lockstep.
// Depends on rhv_pkg.
module rhv_div_step #(
	parameter int CHANNEL_BITS = rhv_pkg::CHANNEL_BITS,
	parameter int SHIFT        = 0
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [CHANNEL_BITS+rhv_pkg::QUO_BITS-1:0] in_rem_h,
	input  logic [CHANNEL_BITS+rhv_pkg::QUO_BITS-1:0] in_rem_s,
	input  logic [CHANNEL_BITS-1:0]                   in_div_h,
	input  logic [CHANNEL_BITS-1:0]                   in_div_s,
	input  logic [rhv_pkg::QUO_BITS-1:0]              in_q_h,
	input  logic [rhv_pkg::QUO_BITS-1:0]              in_q_s,
	input  logic [CHANNEL_BITS-1:0]                   in_top,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [CHANNEL_BITS+rhv_pkg::QUO_BITS-1:0] out_rem_h,
	output logic [CHANNEL_BITS+rhv_pkg::QUO_BITS-1:0] out_rem_s,
	output logic [CHANNEL_BITS-1:0]                   out_div_h,
	output logic [CHANNEL_BITS-1:0]                   out_div_s,
	output logic [rhv_pkg::QUO_BITS-1:0]              out_q_h,
	output logic [rhv_pkg::QUO_BITS-1:0]              out_q_s,
	output logic [CHANNEL_BITS-1:0]                   out_top
);

	localparam int RW = CHANNEL_BITS + rhv_pkg::QUO_BITS;
	localparam int QB = rhv_pkg::QUO_BITS;

	logic          en;
	logic          v_q;
	logic [RW-1:0] dsh_h, dsh_s;
	logic          ge_h, ge_s;

	assign en       = !v_q || out_ready;
	assign in_ready = en;

	assign dsh_h = RW'(in_div_h) << SHIFT;
	assign dsh_s = RW'(in_div_s) << SHIFT;
	assign ge_h  = in_rem_h >= dsh_h;
	assign ge_s  = in_rem_s >= dsh_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (en)
			v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			out_rem_h <= ge_h ? in_rem_h - dsh_h : in_rem_h;
			out_rem_s <= ge_s ? in_rem_s - dsh_s : in_rem_s;
			out_div_h <= in_div_h;
			out_div_s <= in_div_s;
			out_q_h   <= {in_q_h[QB-2:0], ge_h};
			out_q_s   <= {in_q_s[QB-2:0], ge_s};
			out_top   <= in_top;
		end
	end

	assign out_valid = v_q;

endmodule

// File: src/rhv_divider.sv
// Pipelined restoring divider, one quotient bit per stage, hue and saturation paths.
// Depends on rhv_pkg and rhv_div_step.
module rhv_divider #(
	parameter int CHANNEL_BITS = rhv_pkg::CHANNEL_BITS
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [CHANNEL_BITS+rhv_pkg::QUO_BITS-1:0] rem_h,
	input  logic [CHANNEL_BITS+rhv_pkg::QUO_BITS-1:0] rem_s,
	input  logic [CHANNEL_BITS-1:0]                   div_h,
	input  logic [CHANNEL_BITS-1:0]                   div_s,
	input  logic [CHANNEL_BITS-1:0]                   top,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [rhv_pkg::QUO_BITS-1:0]              q_h,
	output logic [rhv_pkg::QUO_BITS-1:0]              q_s,
	output logic [CHANNEL_BITS-1:0]                   out_top
);

	localparam int CB = CHANNEL_BITS;
	localparam int QB = rhv_pkg::QUO_BITS;
	localparam int RW = CB + QB;

	logic          v   [QB+1];
	logic          rdy [QB+1];
	logic [RW-1:0] rh  [QB+1];
	logic [RW-1:0] rs  [QB+1];
	logic [CB-1:0] dh  [QB+1];
	logic [CB-1:0] ds  [QB+1];
	logic [QB-1:0] qh  [QB+1];
	logic [QB-1:0] qs  [QB+1];
	logic [CB-1:0] tp  [QB+1];

	assign v[0]  = in_valid;
	assign rh[0] = rem_h;
	assign rs[0] = rem_s;
	assign dh[0] = div_h;
	assign ds[0] = div_s;
	assign qh[0] = '0;
	assign qs[0] = '0;
	assign tp[0] = top;
	assign in_ready = rdy[0];

	for (genvar i = 0; i < QB; i++) begin : g_step
		rhv_div_step #(
			.CHANNEL_BITS (CHANNEL_BITS),
			.SHIFT        (QB - 1 - i)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[i]),
			.in_ready  (rdy[i]),
			.in_rem_h  (rh[i]),
			.in_rem_s  (rs[i]),
			.in_div_h  (dh[i]),
			.in_div_s  (ds[i]),
			.in_q_h    (qh[i]),
			.in_q_s    (qs[i]),
			.in_top    (tp[i]),
			.out_valid (v[i+1]),
			.out_ready (rdy[i+1]),
			.out_rem_h (rh[i+1]),
			.out_rem_s (rs[i+1]),
			.out_div_h (dh[i+1]),
			.out_div_s (ds[i+1]),
			.out_q_h   (qh[i+1]),
			.out_q_s   (qs[i+1]),
			.out_top   (tp[i+1])
		);
	end

	assign rdy[QB]   = out_ready;
	assign out_valid = v[QB];
	assign q_h       = qh[QB];
	assign q_s       = qs[QB];
	assign out_top   = tp[QB];

endmodule

// File: tb/sv/rgb_to_hsv_integer_core_tb.sv
// Testbench for rgb_to_hsv_integer_core: drives RGB requests, predicts hue, saturation
// and value for each accepted request, and checks every result in order.
// Depends on rhv_pkg, rhv_stream_if and the core.
module rgb_to_hsv_integer_core_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 160;
	localparam int FIELD_W     = rhv_pkg::FIELD_BITS;
	localparam int HUE_W       = rhv_pkg::HUE_BITS;
	localparam int SAT_W       = rhv_pkg::SAT_BITS;

	class hsv_scoreboard;
		rhv_pkg::hsv_t expected_q[$];
		int            mismatches = 0;

		function rhv_pkg::hsv_t predict_hsv(rhv_pkg::pixel_t p);
			int unsigned keep, r, g, b, hi, lo, chroma, scaled;
			rhv_pkg::hsv_t res;
			keep = (32'd1 << rhv_pkg::CHANNEL_BITS) - 1;
			r = p.red & keep;
			g = p.green & keep;
			b = p.blue & keep;
			hi = r;
			if (g > hi) hi = g;
			if (b > hi) hi = b;
			lo = r;
			if (g < lo) lo = g;
			if (b < lo) lo = b;
			chroma = hi - lo;
			if (chroma == 0)
				scaled = 0;
			else if (hi == r)
				scaled = (g >= b) ? g - b : 6 * chroma - (b - g);
			else if (hi == g)
				scaled = (b >= r) ? 2 * chroma + (b - r) : 2 * chroma - (r - b);
			else
				scaled = (r >= g) ? 4 * chroma + (r - g) : 4 * chroma - (g - r);
			res.hue        = (chroma == 0) ? '0 :
				HUE_W'(scaled * rhv_pkg::SECTOR_DEG / chroma);
			res.saturation = (hi == 0) ? '0 : SAT_W'(chroma * rhv_pkg::PCT_FULL / hi);
			res.brightness = FIELD_W'(hi);
			return res;
		endfunction

		function void note_request(rhv_pkg::pixel_t p);
			expected_q.push_back(predict_hsv(p));
		endfunction

		task report_mismatch(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_result(rhv_pkg::hsv_t got);
			rhv_pkg::hsv_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result with no request pending: hue %0d sat %0d val %0d",
					got.hue, got.saturation, got.brightness));
				return;
			end
			want = expected_q.pop_front();
			if (got.hue !== want.hue)
				report_mismatch($sformatf("hue %0d, expected %0d", got.hue, want.hue));
			if (got.saturation !== want.saturation)
				report_mismatch($sformatf("saturation %0d, expected %0d",
					got.saturation, want.saturation));
			if (got.brightness !== want.brightness)
				report_mismatch($sformatf("value %0d, expected %0d",
					got.brightness, want.brightness));
		endtask
	endclass

	bit   clk = 1'b0;
	logic arst_n;
	bit   tx_idle = 1'b0;
	bit   rx_idle = 1'b0;
	bit   hold_req = 1'b0;
	int   cycle_count = 0;

	hsv_scoreboard sb = new();

	rhv_stream_if #(.payload_t(rhv_pkg::pixel_t)) pix_if ();
	rhv_stream_if #(.payload_t(rhv_pkg::hsv_t))   hsv_if ();

	rgb_to_hsv_integer_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_if),
		.hsv    (hsv_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[rgb_to_hsv_integer_core] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_if.valid && pix_if.ready)
				sb.note_request(pix_if.payload);
			if (hsv_if.valid && hsv_if.ready)
				sb.check_result(hsv_if.payload);
		end
	end

	initial begin
		bit hold_seen;
		int hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		hsv_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				hsv_if.ready <= 1'b0;
			end else
				hsv_if.ready <= !(rx_idle && $urandom_range(0, 99) < 30);
		end
	end

	function automatic rhv_pkg::pixel_t rand_pixel();
		logic [FIELD_W-1:0] ch [3];
		int unsigned base, k, sel;
		rhv_pkg::pixel_t p;
		case ($urandom_range(0, 5))
			0, 1: foreach (ch[i]) ch[i] = FIELD_W'($urandom);
			2: foreach (ch[i]) ch[i] = FIELD_W'($urandom_range(0, 7));
			3: begin
				base = $urandom_range(0, 65535 - 8);
				foreach (ch[i]) ch[i] = FIELD_W'(base + $urandom_range(0, 8));
			end
			4: begin
				base = $urandom;
				foreach (ch[i]) ch[i] = FIELD_W'(base);
				k = $urandom_range(0, 2);
				ch[k] = FIELD_W'($urandom);
			end
			default: foreach (ch[i]) begin
				sel = $urandom_range(0, 2);
				ch[i] = (sel == 0) ? '0 : (sel == 1) ? '1 : FIELD_W'($urandom);
			end
		endcase
		p.red   = ch[0];
		p.green = ch[1];
		p.blue  = ch[2];
		return p;
	endfunction

	task automatic pause_pix(input int n);
		repeat (n) begin
			@(negedge clk);
			pix_if.valid <= 1'b0;
		end
	endtask

	task automatic send_pixel(input rhv_pkg::pixel_t p);
		if (tx_idle && $urandom_range(0, 99) < 30)
			pause_pix($urandom_range(1, 2));
		@(negedge clk);
		pix_if.valid   <= 1'b1;
		pix_if.payload <= p;
		do @(posedge clk); while (!pix_if.ready);
	endtask

	task automatic drain_results();
		@(negedge clk);
		pix_if.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random(input int n, input bit idle_on);
		tx_idle = idle_on;
		rx_idle = idle_on;
		repeat (n) send_pixel(rand_pixel());
	endtask

	initial begin
		pix_if.valid   = 1'b0;
		pix_if.payload = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		send_pixel({16'h0000, 16'h0000, 16'h0000});
		send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_pixel({16'hFFFF, 16'h0000, 16'h0000});
		send_pixel({16'h0000, 16'hFFFF, 16'h0000});
		send_pixel({16'h0000, 16'h0000, 16'hFFFF});
		send_pixel({16'hFFFF, 16'h8000, 16'h0000});
		send_pixel({16'hFFFF, 16'h0000, 16'h8000});
		send_pixel({16'hFFFF, 16'h0000, 16'h0001});
		send_pixel({16'hFFFF, 16'h1234, 16'h1234});
		send_pixel({16'h1000, 16'hFFFF, 16'h0800});
		send_pixel({16'h0800, 16'hFFFF, 16'h1000});
		send_pixel({16'h0000, 16'h8000, 16'hFFFF});
		send_pixel({16'h8000, 16'h0000, 16'hFFFF});
		send_pixel({16'hFFFF, 16'hFFFF, 16'h0000});
		send_pixel({16'h0000, 16'hFFFF, 16'hFFFF});
		send_pixel({16'hFFFF, 16'h0000, 16'hFFFF});
		send_pixel({16'h0001, 16'h0000, 16'h0000});
		send_pixel({16'h0000, 16'h0000, 16'h0001});
		send_pixel({16'h0001, 16'h0001, 16'h0001});
		send_pixel({16'hAAAA, 16'h5555, 16'hAAAA});
		send_pixel({16'h5555, 16'hAAAA, 16'h5555});
		send_pixel({16'hFFFE, 16'hFFFF, 16'h0001});
		send_pixel({16'h0000, 16'hFFFF, 16'hFFFE});

		send_random(800, 1'b1);

		// hold the result side off while requests keep coming
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_req = ~hold_req;
		repeat (80) send_pixel(rand_pixel());
		drain_results();

		send_random(300, 1'b0);
		send_random(700, 1'b1);

		drain_results();
		repeat (24) @(posedge clk);
		if (sb.mismatches == 0)
			$display("[rgb_to_hsv_integer_core] OK");
		else
			$display("[rgb_to_hsv_integer_core] ERROR");
		$finish;
	end

endmodule
